[src/nps_pkg.sv]
// Shared types and codes for the non-preemptive priority scheduler.
// No dependencies.
package nps_pkg;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} job_t;

endpackage

[src/nonpreemptive_priority_scheduler.sv]
// Non-preemptive priority scheduler: ready-job memory, dispatch scan, run and finish logic.
// Depends on nps_pkg.
//
// An item is taken with start while busy is low. An arrival is answered in the next cycle.
// A tick while a job runs passes through ST_TICK, and through ST_FIN_TA, ST_FIN_WT and
// ST_FIN_SUM as well when that job finishes. A tick with no job running first scans the
// ready memory, one slot read per cycle, then passes ST_SCAN_END and ST_DISPATCH; when a
// job is dispatched, it goes on as a tick while a job runs. Each item gives one result,
// marked by done for one cycle. done can come in the same cycle that the next item is
// taken. Results are never held back and must be taken when done is high.
module nonpreemptive_priority_scheduler #(
	parameter int READY_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [7:0]  job_id,
	input  logic [31:0] arrival_time,
	input  logic [15:0] burst_length,
	input  logic [7:0]  job_priority,
	output logic        done,
	output logic        accepted,
	output logic        running_valid,
	output logic [7:0]  running_id,
	output logic        finished,
	output logic [31:0] finish_tick,
	output logic [31:0] turnaround,
	output logic [31:0] waiting,
	output logic [47:0] turnaround_sum,
	output logic [47:0] waiting_sum,
	output logic [31:0] dispatch_count,
	output logic [31:0] time_now
);
	import nps_pkg::*;

	localparam int SW = $clog2(READY_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DISPATCH, ST_TICK, ST_FIN_TA, ST_FIN_WT, ST_FIN_SUM
	} state_t;

	state_t                 state_q;
	logic [READY_SLOTS-1:0] valid_q;
	logic                   run_q;
	job_t                   cur_q;
	logic [15:0]            rem_q;
	logic [31:0]            tick_q;
	logic [47:0]            sum_ta_q;
	logic [47:0]            sum_wt_q;
	logic [31:0]            dispatched_q;
	logic [SW-1:0]          cnt_q;
	logic                   found_q;
	job_t                   best_q;
	logic [SW-1:0]          best_idx_q;
	logic [31:0]            ta_q;
	logic [31:0]            wt_q;

	logic                   done_q;
	logic                   accepted_q;
	logic                   running_valid_q;
	logic [7:0]             running_id_q;
	logic                   finished_q;
	logic [31:0]            finish_tick_q;
	logic [31:0]            turnaround_q;
	logic [31:0]            waiting_q;

	job_t                   ready_mem [READY_SLOTS];
	job_t                   rd_job_s1;
	logic [SW-1:0]          rd_idx_s1;
	logic                   rd_chk_s1;

	logic                   take;
	logic                   free_found;
	logic [SW-1:0]          free_idx;
	logic                   mem_we;
	job_t                   wr_job;
	logic                   better;

	assign take = start && !busy;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = READY_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	assign mem_we = take && (opcode == OP_ARRIVE) && free_found && (burst_length != 16'd0);
	assign wr_job = '{id: job_id, arrival: arrival_time, burst: burst_length,
		prio: job_priority};

	assign better = !found_q || (rd_job_s1.prio < best_q.prio) ||
		((rd_job_s1.prio == best_q.prio) && (rd_job_s1.arrival < best_q.arrival));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ready_mem[free_idx] <= wr_job;
		end
		rd_job_s1 <= ready_mem[cnt_q];
		rd_idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			run_q        <= 1'b0;
			rem_q        <= '0;
			tick_q       <= '0;
			sum_ta_q     <= '0;
			sum_wt_q     <= '0;
			dispatched_q <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			rd_chk_s1    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_chk_s1 <= 1'b0;
			if (rd_chk_s1 && better) begin
				found_q    <= 1'b1;
				best_q     <= rd_job_s1;
				best_idx_q <= rd_idx_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (opcode == OP_ARRIVE) begin
							if (mem_we) begin
								valid_q[free_idx] <= 1'b1;
							end
							done_q          <= 1'b1;
							accepted_q      <= mem_we;
							running_valid_q <= 1'b0;
							running_id_q    <= '0;
							finished_q      <= 1'b0;
							finish_tick_q   <= '0;
							turnaround_q    <= '0;
							waiting_q       <= '0;
						end else if (run_q) begin
							state_q <= ST_TICK;
						end else begin
							cnt_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_chk_s1 <= valid_q[cnt_q];
					if (cnt_q == SW'(READY_SLOTS - 1)) begin
						state_q <= ST_SCAN_END;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					if (found_q) begin
						valid_q[best_idx_q] <= 1'b0;
						cur_q               <= best_q;
						rem_q               <= best_q.burst;
						run_q               <= 1'b1;
						dispatched_q        <= dispatched_q + 32'd1;
						state_q             <= ST_TICK;
					end else begin
						tick_q          <= tick_q + 32'd1;
						done_q          <= 1'b1;
						accepted_q      <= 1'b0;
						running_valid_q <= 1'b0;
						running_id_q    <= '0;
						finished_q      <= 1'b0;
						finish_tick_q   <= '0;
						turnaround_q    <= '0;
						waiting_q       <= '0;
						state_q         <= ST_IDLE;
					end
				end
				ST_TICK: begin
					rem_q  <= rem_q - 16'd1;
					tick_q <= tick_q + 32'd1;
					if (rem_q == 16'd1) begin
						state_q <= ST_FIN_TA;
					end else begin
						done_q          <= 1'b1;
						accepted_q      <= 1'b0;
						running_valid_q <= 1'b1;
						running_id_q    <= cur_q.id;
						finished_q      <= 1'b0;
						finish_tick_q   <= '0;
						turnaround_q    <= '0;
						waiting_q       <= '0;
						state_q         <= ST_IDLE;
					end
				end
				ST_FIN_TA: begin
					ta_q    <= tick_q - cur_q.arrival;
					state_q <= ST_FIN_WT;
				end
				ST_FIN_WT: begin
					wt_q    <= (ta_q > {16'd0, cur_q.burst}) ? ta_q - {16'd0, cur_q.burst} : '0;
					state_q <= ST_FIN_SUM;
				end
				ST_FIN_SUM: begin
					sum_ta_q        <= sum_ta_q + {16'd0, ta_q};
					sum_wt_q        <= sum_wt_q + {16'd0, wt_q};
					run_q           <= 1'b0;
					done_q          <= 1'b1;
					accepted_q      <= 1'b0;
					running_valid_q <= 1'b1;
					running_id_q    <= cur_q.id;
					finished_q      <= 1'b1;
					finish_tick_q   <= tick_q;
					turnaround_q    <= ta_q;
					waiting_q       <= wt_q;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign accepted       = accepted_q;
	assign running_valid  = running_valid_q;
	assign running_id     = running_id_q;
	assign finished       = finished_q;
	assign finish_tick    = finish_tick_q;
	assign turnaround     = turnaround_q;
	assign waiting        = waiting_q;
	assign turnaround_sum = sum_ta_q;
	assign waiting_sum    = sum_wt_q;
	assign dispatch_count = dispatched_q;
	assign time_now       = tick_q;

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != ST_IDLE || (start && !busy)))
		else $error("result strobe without an item in flight");

	a_finish_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(done && finished) |-> (running_valid && !run_q))
		else $error("finished job not reported as running or still marked running");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(take && opcode == OP_ARRIVE && (&valid_q)) |=> (done && !accepted))
		else $error("arrival stored into a full ready memory");

	a_dispatch_step: assert property (@(posedge clk) disable iff (!arst_n)
		(dispatched_q != $past(dispatched_q)) |-> (run_q && state_q == ST_TICK))
		else $error("dispatch count moved without a dispatch");

endmodule

[tb/nonpreemptive_priority_scheduler_test.sv]
// Self-checking test of the non-preemptive priority scheduler: a directed table, then
// random arrivals and ticks in three sender pacing phases, checked against a local model.
// Depends on nps_pkg and nonpreemptive_priority_scheduler.
module nonpreemptive_priority_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nps_pkg::*;

	localparam int READY_SLOTS = 16;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic        op;
		logic [7:0]  id;
		logic [31:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} sched_item_t;

	typedef struct packed {
		logic        accepted;
		logic        running_valid;
		logic [7:0]  running_id;
		logic        finished;
		logic [31:0] finish_tick;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [47:0] turnaround_sum;
		logic [47:0] waiting_sum;
		logic [31:0] dispatch_count;
		logic [31:0] time_now;
	} sched_result_t;

	typedef struct {
		sched_item_t   item;
		bit            typed;
		sched_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        opcode = OP_ARRIVE;
	logic [7:0]  job_id = '0;
	logic [31:0] arrival_time = '0;
	logic [15:0] burst_length = '0;
	logic [7:0]  job_priority = '0;
	logic        busy;
	logic        done;
	logic        accepted;
	logic        running_valid;
	logic [7:0]  running_id;
	logic        finished;
	logic [31:0] finish_tick;
	logic [31:0] turnaround;
	logic [31:0] waiting;
	logic [47:0] turnaround_sum;
	logic [47:0] waiting_sum;
	logic [31:0] dispatch_count;
	logic [31:0] time_now;

	nonpreemptive_priority_scheduler #(.READY_SLOTS(READY_SLOTS)) DUT (
		.clk, .arst_n, .start, .busy, .opcode, .job_id, .arrival_time, .burst_length,
		.job_priority, .done, .accepted, .running_valid, .running_id, .finished,
		.finish_tick, .turnaround, .waiting, .turnaround_sum, .waiting_sum,
		.dispatch_count, .time_now
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scheduler model state
	job_t        slot_job [READY_SLOTS];
	logic [READY_SLOTS-1:0] slot_used = '0;
	logic        running = 1'b0;
	job_t        run_job;
	logic [15:0] ticks_left = '0;
	logic [31:0] clock_ticks = '0;
	logic [47:0] ta_total = '0;
	logic [47:0] wait_total = '0;
	logic [31:0] dispatches = '0;

	sched_result_t pending_outcomes [$];
	int sender_gap_pct = 0;
	int errors = 0;
	int items_sent = 0;
	int jobs_stored = 0;
	int jobs_finished = 0;
	int results_checked = 0;
	int cycles = 0;
	dir_row_t dir_rows [25];

	function automatic sched_item_t job_item(logic op, logic [7:0] id, logic [31:0] arr,
		logic [15:0] burst, logic [7:0] prio);
		return '{op, id, arr, burst, prio};
	endfunction

	function automatic sched_result_t outcome(logic acc, logic rv, logic [7:0] rid,
		logic fin, logic [31:0] ft, logic [31:0] ta, logic [31:0] wt, logic [47:0] tsum,
		logic [47:0] wsum, logic [31:0] dc, logic [31:0] tn);
		return '{acc, rv, rid, fin, ft, ta, wt, tsum, wsum, dc, tn};
	endfunction

	function automatic sched_result_t schedule_step(sched_item_t it);
		sched_result_t r;
		int slot;
		int best;
		logic [31:0] ta;
		logic [31:0] wt;
		r = '0;
		slot = -1;
		best = -1;
		if (it.op == OP_ARRIVE) begin
			for (int i = 0; i < READY_SLOTS; i++)
				if (!slot_used[i] && slot < 0) slot = i;
			if (slot >= 0 && it.burst != 16'd0) begin
				slot_job[slot] = '{id: it.id, arrival: it.arrival, burst: it.burst,
					prio: it.prio};
				slot_used[slot] = 1'b1;
				r.accepted = 1'b1;
			end
		end else begin
			if (!running) begin
				for (int i = 0; i < READY_SLOTS; i++)
					if (slot_used[i] && (best < 0 || slot_job[i].prio < slot_job[best].prio ||
						(slot_job[i].prio == slot_job[best].prio &&
						slot_job[i].arrival < slot_job[best].arrival)))
						best = i;
				if (best >= 0) begin
					run_job = slot_job[best];
					slot_used[best] = 1'b0;
					ticks_left = run_job.burst;
					running = 1'b1;
					dispatches = dispatches + 32'd1;
				end
			end
			clock_ticks = clock_ticks + 32'd1;
			if (running) begin
				r.running_valid = 1'b1;
				r.running_id = run_job.id;
				ticks_left = ticks_left - 16'd1;
				if (ticks_left == 16'd0) begin
					ta = clock_ticks - run_job.arrival;
					wt = (ta > {16'd0, run_job.burst}) ? ta - {16'd0, run_job.burst} : 32'd0;
					r.finished = 1'b1;
					r.finish_tick = clock_ticks;
					r.turnaround = ta;
					r.waiting = wt;
					ta_total = ta_total + {16'd0, ta};
					wait_total = wait_total + {16'd0, wt};
					running = 1'b0;
				end
			end
		end
		r.turnaround_sum = ta_total;
		r.waiting_sum = wait_total;
		r.dispatch_count = dispatches;
		r.time_now = clock_ticks;
		return r;
	endfunction

	function automatic sched_item_t random_item(int arrive_pct);
		sched_item_t it;
		int unsigned pick;
		it.op = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_TICK;
		it.id = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 10)
			it.arrival = $urandom();
		else if (pick < 20)
			it.arrival = clock_ticks + $urandom_range(1, 8);
		else
			it.arrival = clock_ticks - $urandom_range(0, 20);
		pick = $urandom_range(99);
		if (pick < 5)
			it.burst = 16'd0;
		else if (pick < 85)
			it.burst = 16'($urandom_range(1, 6));
		else
			it.burst = 16'($urandom_range(1, 60));
		it.prio = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		return it;
	endfunction

	task automatic send_item(sched_item_t it, bit typed, sched_result_t want);
		sched_result_t predicted;
		if ($urandom_range(99) < sender_gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
		end
		start <= 1'b1;
		opcode <= it.op;
		job_id <= it.id;
		arrival_time <= it.arrival;
		burst_length <= it.burst;
		job_priority <= it.prio;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = schedule_step(it);
		pending_outcomes.push_back(typed ? want : predicted);
		items_sent++;
		if (predicted.accepted) jobs_stored++;
		if (predicted.finished) jobs_finished++;
	endtask

	// hold start low until every outstanding result is back
	task automatic drain_outcomes();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(int gap_pct, int count, int arrive_pct);
		sender_gap_pct = gap_pct;
		repeat (count) send_item(random_item(arrive_pct), 1'b0, '0);
		drain_outcomes();
	endtask

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		sched_result_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: result with no item outstanding", $time);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				results_checked++;
				check_field("accepted", 48'(want.accepted), 48'(accepted));
				check_field("running_valid", 48'(want.running_valid), 48'(running_valid));
				check_field("running_id", 48'(want.running_id), 48'(running_id));
				check_field("finished", 48'(want.finished), 48'(finished));
				check_field("finish_tick", 48'(want.finish_tick), 48'(finish_tick));
				check_field("turnaround", 48'(want.turnaround), 48'(turnaround));
				check_field("waiting", 48'(want.waiting), 48'(waiting));
				check_field("turnaround_sum", want.turnaround_sum, turnaround_sum);
				check_field("waiting_sum", want.waiting_sum, waiting_sum);
				check_field("dispatch_count", 48'(want.dispatch_count), 48'(dispatch_count));
				check_field("time_now", 48'(want.time_now), 48'(time_now));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding", $time,
				pending_outcomes.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		dir_rows = '{
			'{job_item(OP_TICK, 8'h00, 32'h0, 16'h0, 8'h00), 1'b1,
				outcome(0, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1)},
			'{job_item(OP_ARRIVE, 8'hFF, 32'hFFFFFFFF, 16'h0, 8'h00), 1'b1,
				outcome(0, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1)},
			'{job_item(OP_ARRIVE, 8'h01, 32'h0, 16'h1, 8'hFF), 1'b1,
				outcome(1, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1)},
			'{job_item(OP_TICK, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF), 1'b1,
				outcome(0, 1, 8'h01, 1, 2, 2, 1, 2, 1, 1, 2)},
			'{job_item(OP_ARRIVE, 8'h10, 32'hFFFFFFFF, 16'h3, 8'h00), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h11, 32'h00000000, 16'h2, 8'h00), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h12, 32'h00000000, 16'h1, 8'h00), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h13, 32'h00000001, 16'h2, 8'h80), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h14, 32'h00000002, 16'h1, 8'h7F), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h15, 32'h7FFFFFFF, 16'h4, 8'hFF), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h16, 32'h80000000, 16'h1, 8'hFE), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h00, 32'h00000002, 16'h2, 8'h01), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'hFF, 32'h00000002, 16'h1, 8'h01), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h55, 32'h00000002, 16'h3, 8'h55), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'hAA, 32'h00000003, 16'h1, 8'hAA), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h20, 32'h00000003, 16'h2, 8'h02), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h21, 32'h00000001, 16'h1, 8'h02), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h22, 32'h00000000, 16'h5, 8'h10), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h23, 32'h00000004, 16'h1, 8'h10), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h24, 32'hFFFFFFFE, 16'h2, 8'h03), 1'b0, '0},
			'{job_item(OP_ARRIVE, 8'h77, 32'h00000002, 16'h1, 8'h00), 1'b1,
				outcome(0, 0, 8'h00, 0, 0, 0, 0, 2, 1, 1, 2)},
			'{job_item(OP_TICK, 8'h00, 32'h0, 16'h0, 8'h00), 1'b0, '0},
			'{job_item(OP_TICK, 8'h00, 32'h0, 16'h0, 8'h00), 1'b0, '0},
			'{job_item(OP_TICK, 8'h00, 32'h0, 16'h0, 8'h00), 1'b0, '0},
			'{job_item(OP_TICK, 8'h00, 32'h0, 16'h0, 8'h00), 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gap_pct = 9;
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		drain_outcomes();

		run_phase(9, 400, 25);
		run_phase(79, 400, 15);
		run_phase(0, 400, 20);

		// run the store dry, including one long job
		send_item(job_item(OP_ARRIVE, 8'hA5, clock_ticks, 16'd100, 8'h00), 1'b0, '0);
		while (running || slot_used != '0)
			send_item(random_item(0), 1'b0, '0);
		drain_outcomes();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_outcomes.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, pending_outcomes.size());
			errors++;
		end
		$display("%0d items (%0d jobs stored, %0d dispatched, %0d finished), %0d results",
			items_sent, jobs_stored, dispatches, jobs_finished, results_checked);
		$display("pacing phases of 9, 79 and 0 percent sender gaps, one long job, %0d errors",
			errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[nonpreemptive_priority_scheduler.f]
src/nps_pkg.sv
src/nonpreemptive_priority_scheduler.sv
tb/nonpreemptive_priority_scheduler_test.sv
